FILE: hw/rtl/bfba_pkg.sv
// bfba_pkg: shared constants for the bloom filter bit array
// no dependencies; imported by bfba_div and bloom_filter_bit_array

package bfba_pkg;

    localparam int MAX_BITS_LOG2 = 20;
    localparam int MAX_HASHES    = 16;

    localparam int ROW_LOG2 = 6;
    localparam int ROW_W    = 1 << ROW_LOG2;
    localparam int ROW_AW   = MAX_BITS_LOG2 - ROW_LOG2;
    localparam int ROWS     = 1 << ROW_AW;

    localparam int HASH_W     = 64;
    localparam int NUM_BITS_W = 21;
    localparam int HASH_CNT_W = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BITS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 1'd1;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEST   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MODULO = 2'd2;

    localparam logic [NUM_BITS_W-1:0] BITS_CAP         = NUM_BITS_W'(64'd1 << MAX_BITS_LOG2);
    localparam logic [HASH_CNT_W-1:0] HASH_COUNT_RESET = 5'd4;
    localparam logic [HASH_CNT_W-1:0] HASH_COUNT_MAX   = HASH_CNT_W'(MAX_HASHES);
    localparam logic [NUM_BITS_W-1:0] COUNT_MAX        = '1;

endpackage

FILE: hw/rtl/bfba_ram.sv
// bfba_ram: generic single write port, single read port ram
// registered read; no dependencies

module bfba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/bfba_div.sv
// bfba_div: bit-serial remainder unit, one dividend bit per cycle
// depends on bfba_pkg

module bfba_div
    import bfba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [HASH_W-1:0]     i_dividend,
    input  logic [NUM_BITS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [NUM_BITS_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(HASH_W);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [HASH_W-1:0]     r_dvd, n_dvd;
    logic [NUM_BITS_W-1:0] r_dvs, n_dvs;
    logic [NUM_BITS_W-1:0] r_rem, n_rem;
    logic [NUM_BITS_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        trial  = {r_rem, r_dvd[HASH_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(HASH_W - 1);
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // restoring step
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = NUM_BITS_W'(trial - {1'b0, r_dvs});
            end else begin
                n_rem = trial[NUM_BITS_W-1:0];
            end
            n_dvd = {r_dvd[HASH_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("remainder done while still stepping");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("remainder unit restarted while busy");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");

endmodule

FILE: hw/rtl/bloom_filter_bit_array.sv
// bloom_filter_bit_array: top level, bit array in a row ram with read-modify-write
// depends on bfba_pkg, bfba_ram, bfba_div
//
// channel  direction  transfer
// item     in         i_start high and o_busy low: i_mode, i_hash_value, i_modulus
// result   out        o_valid high for one cycle: o_member, o_set_bits, o_range_error
// config   in         i_cfg_valid and o_cfg_ready high: i_cfg_index, i_cfg_data
//
// insert or test item: one row read, then for an insert a write-back through the ram port
// out-of-range or zero-modulus item: finishes with a range error; modulo item: runs
// the 64-step remainder unit, then the row read-modify-write
// (no read-modify-write, but a range error, when the remainder lands out of range)
// after reset a clearing pass over 16384 rows (one row a cycle) keeps o_busy high
// result appears the cycle after the group's last item completes; no stall on output

module bloom_filter_bit_array
    import bfba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [HASH_W-1:0]     i_hash_value,
    input  logic [NUM_BITS_W-1:0] i_modulus,
    output logic                  o_valid,
    output logic                  o_member,
    output logic [NUM_BITS_W-1:0] o_set_bits,
    output logic                  o_range_error,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [NUM_BITS_W-1:0] i_cfg_data
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_RMW   = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [ROW_AW-1:0]     r_clr_row, n_clr_row;
    logic [NUM_BITS_W-1:0] r_num_bits, n_num_bits;
    logic [HASH_CNT_W-1:0] r_hash_count, n_hash_count;
    logic [HASH_CNT_W-1:0] r_group_pos, n_group_pos;
    logic [MODE_W-1:0]     r_group_mode, n_group_mode;
    logic                  r_all_set, n_all_set;
    logic                  r_err, n_err;
    logic [NUM_BITS_W-1:0] r_set_count, n_set_count;
    logic [MODE_W-1:0]     r_mode, n_mode;
    logic [ROW_AW-1:0]     r_row, n_row;
    logic [ROW_LOG2-1:0]   r_bit, n_bit;
    logic                  r_out_valid, n_out_valid;
    logic                  r_member, n_member;
    logic [NUM_BITS_W-1:0] r_out_bits, n_out_bits;
    logic                  r_out_err, n_out_err;

    logic [NUM_BITS_W-1:0] eff_bits;
    logic [HASH_CNT_W-1:0] eff_hashes;
    logic [MODE_W-1:0]     item_mode;
    logic                  direct_ok;
    logic                  rem_ok;
    logic                  fin, fin_err, fin_clear;
    logic [MODE_W-1:0]     fin_mode;
    logic                  all_nx, err_nx;
    logic [HASH_CNT_W-1:0] gp_inc;
    logic                  hit;

    logic                  ram_we, ram_re;
    logic [ROW_AW-1:0]     ram_waddr, ram_raddr;
    logic [ROW_W-1:0]      ram_wdata, ram_rdata;

    logic                  div_start, div_done;
    logic [NUM_BITS_W-1:0] div_rem;

    bfba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bfba_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_hash_value),
        .i_divisor   (i_modulus),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    assign eff_bits  = (r_num_bits > BITS_CAP) ? BITS_CAP : r_num_bits;
    assign item_mode = (r_group_pos == '0) ? i_mode : r_group_mode;
    assign direct_ok = (i_hash_value[HASH_W-1:NUM_BITS_W] == '0)
                    && (i_hash_value[NUM_BITS_W-1:0] < eff_bits);
    assign rem_ok    = div_rem < eff_bits;
    assign hit       = ram_rdata[r_bit];
    assign gp_inc    = r_group_pos + HASH_CNT_W'(1);

    always_comb begin
        if (r_hash_count == '0) begin
            eff_hashes = HASH_CNT_W'(1);
        end else if (r_hash_count > HASH_COUNT_MAX) begin
            eff_hashes = HASH_COUNT_MAX;
        end else begin
            eff_hashes = r_hash_count;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_row    = r_clr_row;
        n_num_bits   = r_num_bits;
        n_hash_count = r_hash_count;
        n_group_pos  = r_group_pos;
        n_group_mode = r_group_mode;
        n_all_set    = r_all_set;
        n_err        = r_err;
        n_set_count  = r_set_count;
        n_mode       = r_mode;
        n_row        = r_row;
        n_bit        = r_bit;
        n_out_valid  = 1'b0;
        n_member     = r_member;
        n_out_bits   = r_out_bits;
        n_out_err    = r_out_err;
        fin          = 1'b0;
        fin_err      = 1'b0;
        fin_clear    = 1'b0;
        fin_mode     = r_mode;
        ram_we       = 1'b0;
        ram_waddr    = r_row;
        ram_wdata    = ram_rdata | (ROW_W'(1) << r_bit);
        ram_re       = 1'b0;
        ram_raddr    = i_hash_value[MAX_BITS_LOG2-1:ROW_LOG2];
        div_start    = 1'b0;
        all_nx       = r_all_set;
        err_nx       = r_err;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_BITS:   n_num_bits   = i_cfg_data;
                CFG_HASH_COUNT: n_hash_count = i_cfg_data[HASH_CNT_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_row;
                ram_wdata = '0;
                n_clr_row = r_clr_row + ROW_AW'(1);
                if (&r_clr_row) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_mode   = item_mode;
                    fin_mode = item_mode;
                    if (r_group_pos == '0) begin
                        n_group_mode = i_mode;
                    end
                    if (item_mode == MODE_MODULO) begin
                        if (i_modulus == '0) begin
                            fin     = 1'b1;
                            fin_err = 1'b1;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end else if (direct_ok) begin
                        ram_re  = 1'b1;
                        n_row   = i_hash_value[MAX_BITS_LOG2-1:ROW_LOG2];
                        n_bit   = i_hash_value[ROW_LOG2-1:0];
                        n_state = S_RMW;
                    end else begin
                        fin     = 1'b1;
                        fin_err = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (rem_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = div_rem[MAX_BITS_LOG2-1:ROW_LOG2];
                        n_row     = div_rem[MAX_BITS_LOG2-1:ROW_LOG2];
                        n_bit     = div_rem[ROW_LOG2-1:0];
                        n_state   = S_RMW;
                    end else begin
                        fin     = 1'b1;
                        fin_err = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_RMW: begin
                // the write-back lands before the next read can issue
                fin     = 1'b1;
                n_state = S_IDLE;
                if (r_mode == MODE_INSERT) begin
                    if (!hit) begin
                        ram_we = 1'b1;
                        if (r_set_count != COUNT_MAX) begin
                            n_set_count = r_set_count + NUM_BITS_W'(1);
                        end
                    end
                end else begin
                    fin_clear = !hit;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            all_nx = r_all_set & !fin_clear;
            err_nx = r_err | fin_err;
            if (gp_inc >= eff_hashes) begin
                n_out_valid = 1'b1;
                n_member    = (fin_mode == MODE_INSERT) | all_nx;
                n_out_bits  = n_set_count;
                n_out_err   = err_nx;
                n_group_pos = '0;
                n_all_set   = 1'b1;
                n_err       = 1'b0;
            end else begin
                n_group_pos = gp_inc;
                n_all_set   = all_nx;
                n_err       = err_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_row    <= '0;
            r_num_bits   <= BITS_CAP;
            r_hash_count <= HASH_COUNT_RESET;
            r_group_pos  <= '0;
            r_group_mode <= MODE_INSERT;
            r_all_set    <= 1'b1;
            r_err        <= 1'b0;
            r_set_count  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_row    <= n_clr_row;
            r_num_bits   <= n_num_bits;
            r_hash_count <= n_hash_count;
            r_group_pos  <= n_group_pos;
            r_group_mode <= n_group_mode;
            r_all_set    <= n_all_set;
            r_err        <= n_err;
            r_set_count  <= n_set_count;
            r_out_valid  <= n_out_valid;
        end
        r_mode     <= n_mode;
        r_row      <= n_row;
        r_bit      <= n_bit;
        r_member   <= n_member;
        r_out_bits <= n_out_bits;
        r_out_err  <= n_out_err;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_member      = r_member;
    assign o_set_bits    = r_out_bits;
    assign o_range_error = r_out_err;

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");

    a_write_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW && ram_we) |-> (r_mode == MODE_INSERT))
        else $error("array written by a test item");

    a_group_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group_pos < HASH_COUNT_MAX)
        else $error("group position beyond hash limit");

    a_count_monotonic: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_set_count >= $past(r_set_count)))
        else $error("set bit count went down");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("remainder finished outside modulo wait");

endmodule
